[rtl/obb_overlap_separating_axis_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the box overlap block
// Clocked assertion shorthands, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef OBB_OVERLAP_SEPARATING_AXIS_ASSERT_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_ASSERT_SVH

// same-cycle implication
`define OBBSAT_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define OBBSAT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/obbsat_pkg.sv]
// ---------------------------------------------------------------------------
// obbsat_pkg
// Shared widths and types for the box-box separating axis pipeline.
// ---------------------------------------------------------------------------
package obbsat_pkg;

	localparam int COMP_WIDTH  = 20;
	localparam int DIR_FRAC    = 18;
	localparam int FIELD_W     = 60;
	localparam int NUM_FIELDS  = 10;
	localparam int IN_TDATA_W  = FIELD_W * NUM_FIELDS;
	localparam int OUT_TDATA_W = 8;

	localparam int IV_W  = COMP_WIDTH + 1;       // centre difference
	localparam int PP_W  = 2 * COMP_WIDTH;       // direction x direction
	localparam int DNN_W = PP_W + 2;             // dot of two directions
	localparam int CRS_W = PP_W + 1;             // cross product component
	localparam int PIV_W = IV_W + COMP_WIDTH;    // centre x direction
	localparam int DIV_W = PIV_W + 2;            // dot of centre diff and direction

	localparam int NSTG = 12;

	typedef logic [NSTG:1] stage_en_t;
	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic [COMP_WIDTH-1:0] mag_t;
	typedef logic signed [IV_W-1:0] ivc_t;
	typedef logic signed [CRS_W-1:0] crs_t;

endpackage

[rtl/obbsat_cross_axis.sv]
// ---------------------------------------------------------------------------
// obbsat_cross_axis
// One edge-edge axis: projects the centre difference and four box radii
// onto a cross product axis and flags separation. Stages 4 to 11.
// ---------------------------------------------------------------------------
module obbsat_cross_axis #(
	parameter int DIR_FRAC = obbsat_pkg::DIR_FRAC
) (
	input  logic                  clk,
	input  obbsat_pkg::stage_en_t en,
	input  obbsat_pkg::ivc_t      iv   [3],
	input  obbsat_pkg::crs_t      crs  [3],
	input  obbsat_pkg::comp_t     dir  [4][3],
	input  obbsat_pkg::mag_t      len  [4],
	output logic                  sep_s11
);

	localparam int CW    = obbsat_pkg::COMP_WIDTH;
	localparam int OP_W  = obbsat_pkg::IV_W;
	localparam int CR_W  = obbsat_pkg::CRS_W;
	localparam int CLO   = CW + 1;
	localparam int PL_W  = OP_W + CLO + 1;
	localparam int PH_W  = OP_W + CR_W - CLO;
	localparam int XP_W  = OP_W + CR_W;
	localparam int XD_W  = XP_W + 2;
	localparam int PC    = (XD_W + 2) / 3;
	localparam int PAD_W = 3 * PC;
	localparam int PR_W  = CW + PC;
	localparam int PJ_W  = CW + PAD_W;
	localparam int RS_W  = PJ_W + 2;
	localparam int LS_W  = XD_W + DIR_FRAC;
	localparam int CMP_W = (LS_W > RS_W) ? LS_W : RS_W;

	// operand 0 is the centre difference, 1..4 the box directions
	logic signed [OP_W-1:0] opr [5][3];
	logic [PAD_W-1:0]       xa_pad [4];

	logic signed [PL_W-1:0] pl_s4 [5][3];
	logic signed [PH_W-1:0] ph_s4 [5][3];
	obbsat_pkg::mag_t       len_s4 [4];
	logic signed [XP_W-1:0] xp_s5 [5][3];
	obbsat_pkg::mag_t       len_s5 [4];
	logic signed [XD_W-1:0] xd_s6 [5];
	obbsat_pkg::mag_t       len_s6 [4];
	logic [XD_W-1:0]        xa_s7 [5];
	obbsat_pkg::mag_t       len_s7 [4];
	logic [PR_W-1:0]        pr_s8 [4][3];
	logic [XD_W-1:0]        l_s8;
	logic [PJ_W-1:0]        pj_s9 [4];
	logic [XD_W-1:0]        l_s9;
	logic [RS_W-1:0]        rs_s10;
	logic [XD_W-1:0]        l_s10;

	always_comb begin
		for (int x = 0; x < 3; x++) begin
			opr[0][x] = iv[x];
			for (int t = 1; t < 5; t++) begin
				opr[t][x] = obbsat_pkg::ivc_t'(dir[t-1][x]);
			end
		end
		for (int t = 0; t < 4; t++) begin
			xa_pad[t] = PAD_W'(xa_s7[t+1]);
		end
	end

	// cross component split into an unsigned low part and a signed high part
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int t = 0; t < 5; t++) begin
				for (int x = 0; x < 3; x++) begin
					pl_s4[t][x] <= opr[t][x] * $signed({1'b0, crs[x][CLO-1:0]});
					ph_s4[t][x] <= opr[t][x] * $signed(crs[x][CR_W-1:CLO]);
				end
			end
			len_s4 <= len;
		end
		if (en[5]) begin
			for (int t = 0; t < 5; t++) begin
				for (int x = 0; x < 3; x++) begin
					xp_s5[t][x] <= (XP_W'(ph_s4[t][x]) <<< CLO) + XP_W'(pl_s4[t][x]);
				end
			end
			len_s5 <= len_s4;
		end
		if (en[6]) begin
			for (int t = 0; t < 5; t++) begin
				xd_s6[t] <= XD_W'(xp_s5[t][0]) + XD_W'(xp_s5[t][1]) + XD_W'(xp_s5[t][2]);
			end
			len_s6 <= len_s5;
		end
		if (en[7]) begin
			for (int t = 0; t < 5; t++) begin
				xa_s7[t] <= xd_s6[t][XD_W-1] ? XD_W'(-xd_s6[t]) : XD_W'(xd_s6[t]);
			end
			len_s7 <= len_s6;
		end
		if (en[8]) begin
			for (int t = 0; t < 4; t++) begin
				for (int m = 0; m < 3; m++) begin
					pr_s8[t][m] <= len_s7[t] * xa_pad[t][m*PC +: PC];
				end
			end
			l_s8 <= xa_s7[0];
		end
		if (en[9]) begin
			for (int t = 0; t < 4; t++) begin
				pj_s9[t] <= PJ_W'(pr_s8[t][0]) + (PJ_W'(pr_s8[t][1]) << PC)
					+ (PJ_W'(pr_s8[t][2]) << (2 * PC));
			end
			l_s9 <= l_s8;
		end
		if (en[10]) begin
			rs_s10 <= RS_W'(pj_s9[0]) + RS_W'(pj_s9[1]) + RS_W'(pj_s9[2]) + RS_W'(pj_s9[3]);
			l_s10  <= l_s9;
		end
		if (en[11]) begin
			sep_s11 <= (CMP_W'(l_s10) << DIR_FRAC) > CMP_W'(rs_s10);
		end
	end

endmodule

[rtl/obb_overlap_separating_axis.sv]
// ---------------------------------------------------------------------------
// obb_overlap_separating_axis
// Oriented box pair overlap by the 15-axis separating axis test.
// ---------------------------------------------------------------------------
//  channel  dir  word                         handshake
//  s_axis   in   ten 60-bit box fields        tvalid/tready
//  m_axis   out  overlap flag (bit 0)         tvalid/tready
//
//  One word per cycle sustained while the output is not stalled, through a
//  12-stage pipeline whose depth is set by the split 64-bit projection multiplies.
//  Reset clears the stage valid flags only.
//  A stalled stage holds its word; empty stages upstream keep filling.
// ---------------------------------------------------------------------------
module obb_overlap_separating_axis #(
	parameter int DIR_FRAC = obbsat_pkg::DIR_FRAC
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// a_center, a_half_len, a_axis_u, a_axis_v, a_axis_w,
	// b_center, b_half_len, b_axis_u, b_axis_v, b_axis_w (60 bits each)
	input  logic [obbsat_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// overlap, then zero fill
	output logic [obbsat_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int CW     = obbsat_pkg::COMP_WIDTH;
	localparam int FW     = obbsat_pkg::FIELD_W;
	localparam int NSTG   = obbsat_pkg::NSTG;
	localparam int DNN_W  = obbsat_pkg::DNN_W;
	localparam int DIV_W  = obbsat_pkg::DIV_W;
	localparam int PIV_W  = obbsat_pkg::PIV_W;
	localparam int PP_W   = obbsat_pkg::PP_W;
	localparam int FL     = (DNN_W + 1) / 2;
	localparam int PADF   = 2 * FL;
	localparam int PFP_W  = CW + FL;
	localparam int PF_W   = CW + PADF;
	localparam int CST_W  = CW + 2 * DIR_FRAC;
	localparam int FR_W   = ((CST_W > PF_W) ? CST_W : PF_W) + 2;
	localparam int FL_W   = DIV_W + DIR_FRAC;
	localparam int CMPF_W = (FL_W > FR_W) ? FL_W : FR_W;

	localparam int F_A_CENTER = 0;
	localparam int F_A_HALF   = 1;
	localparam int F_A_AXIS   = 2;
	localparam int F_B_CENTER = 5;
	localparam int F_B_HALF   = 6;
	localparam int F_B_AXIS   = 7;

	obbsat_pkg::stage_en_t en;
	logic [NSTG:1]         valid_q;

	obbsat_pkg::comp_t fld [obbsat_pkg::NUM_FIELDS][3];

	obbsat_pkg::ivc_t  iv_s1 [3];
	obbsat_pkg::comp_t na_s1 [3][3];
	obbsat_pkg::comp_t nb_s1 [3][3];
	obbsat_pkg::mag_t  mla_s1 [3];
	obbsat_pkg::mag_t  mlb_s1 [3];

	logic signed [PP_W-1:0]  pp_s2 [3][3][3][3];
	logic signed [PIV_W-1:0] pia_s2 [3][3];
	logic signed [PIV_W-1:0] pib_s2 [3][3];
	obbsat_pkg::ivc_t        iv_s2 [3];
	obbsat_pkg::comp_t       na_s2 [3][3];
	obbsat_pkg::comp_t       nb_s2 [3][3];
	obbsat_pkg::mag_t        mla_s2 [3];
	obbsat_pkg::mag_t        mlb_s2 [3];

	logic signed [DNN_W-1:0] dnn_s3 [3][3];
	obbsat_pkg::crs_t        crs_s3 [3][3][3];
	logic signed [DIV_W-1:0] dia_s3 [3];
	logic signed [DIV_W-1:0] dib_s3 [3];
	obbsat_pkg::ivc_t        iv_s3 [3];
	obbsat_pkg::comp_t       na_s3 [3][3];
	obbsat_pkg::comp_t       nb_s3 [3][3];
	obbsat_pkg::mag_t        mla_s3 [3];
	obbsat_pkg::mag_t        mlb_s3 [3];

	logic [DNN_W-1:0]  anm_s4 [3][3];
	logic [DIV_W-1:0]  aia_s4 [3];
	logic [DIV_W-1:0]  aib_s4 [3];
	obbsat_pkg::mag_t  mla_s4 [3];
	obbsat_pkg::mag_t  mlb_s4 [3];
	logic [PADF-1:0]   anm_pad [3][3];

	logic [PFP_W-1:0]  pfa_s5 [3][3][2];
	logic [PFP_W-1:0]  pfb_s5 [3][3][2];
	logic [DIV_W-1:0]  aia_s5 [3];
	logic [DIV_W-1:0]  aib_s5 [3];
	obbsat_pkg::mag_t  mla_s5 [3];
	obbsat_pkg::mag_t  mlb_s5 [3];

	logic [PF_W-1:0]   pja_s6 [3][3];
	logic [PF_W-1:0]   pjb_s6 [3][3];
	logic [DIV_W-1:0]  aia_s6 [3];
	logic [DIV_W-1:0]  aib_s6 [3];
	obbsat_pkg::mag_t  mla_s6 [3];
	obbsat_pkg::mag_t  mlb_s6 [3];

	logic [FR_W-1:0]   rfa_s7 [3];
	logic [FR_W-1:0]   rfb_s7 [3];
	logic [DIV_W-1:0]  aia_s7 [3];
	logic [DIV_W-1:0]  aib_s7 [3];

	logic [5:0] sepf_s8;
	logic [5:0] sepf_s9;
	logic [5:0] sepf_s10;
	logic [5:0] sepf_s11;
	logic [8:0] sepx;
	logic       ovl_s12;

	// stage k may load when it is empty or its word moves on
	always_comb begin
		en[NSTG] = !valid_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = valid_q[NSTG];
	assign m_axis_tdata  = {(obbsat_pkg::OUT_TDATA_W - 1)'(0), ovl_s12};

	always_comb begin
		for (int f = 0; f < obbsat_pkg::NUM_FIELDS; f++) begin
			for (int k = 0; k < 3; k++) begin
				fld[f][k] = obbsat_pkg::comp_t'(s_axis_tdata[FW*f + CW*k +: CW]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				anm_pad[i][j] = PADF'(anm_s4[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: unpack, centre difference, half-length magnitudes
		if (en[1]) begin
			for (int k = 0; k < 3; k++) begin
				iv_s1[k]  <= obbsat_pkg::ivc_t'(fld[F_A_CENTER][k])
					- obbsat_pkg::ivc_t'(fld[F_B_CENTER][k]);
				mla_s1[k] <= obbsat_pkg::mag_t'(fld[F_A_HALF][k][CW-1] ?
					-fld[F_A_HALF][k] : fld[F_A_HALF][k]);
				mlb_s1[k] <= obbsat_pkg::mag_t'(fld[F_B_HALF][k][CW-1] ?
					-fld[F_B_HALF][k] : fld[F_B_HALF][k]);
				for (int i = 0; i < 3; i++) begin
					na_s1[i][k] <= fld[F_A_AXIS + i][k];
					nb_s1[i][k] <= fld[F_B_AXIS + i][k];
				end
			end
		end
		// stage 2: all direction pair products and centre projections
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int p = 0; p < 3; p++) begin
						for (int q = 0; q < 3; q++) begin
							pp_s2[i][j][p][q] <= na_s1[i][p] * nb_s1[j][q];
						end
					end
					pia_s2[i][j] <= iv_s1[j] * na_s1[i][j];
					pib_s2[i][j] <= iv_s1[j] * nb_s1[i][j];
				end
			end
			iv_s2  <= iv_s1;
			na_s2  <= na_s1;
			nb_s2  <= nb_s1;
			mla_s2 <= mla_s1;
			mlb_s2 <= mlb_s1;
		end
		// stage 3: dots and cross components
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					dnn_s3[i][j] <= DNN_W'(pp_s2[i][j][0][0]) + DNN_W'(pp_s2[i][j][1][1])
						+ DNN_W'(pp_s2[i][j][2][2]);
					crs_s3[i][j][0] <= obbsat_pkg::crs_t'(pp_s2[i][j][1][2])
						- obbsat_pkg::crs_t'(pp_s2[i][j][2][1]);
					crs_s3[i][j][1] <= obbsat_pkg::crs_t'(pp_s2[i][j][2][0])
						- obbsat_pkg::crs_t'(pp_s2[i][j][0][2]);
					crs_s3[i][j][2] <= obbsat_pkg::crs_t'(pp_s2[i][j][0][1])
						- obbsat_pkg::crs_t'(pp_s2[i][j][1][0]);
				end
				dia_s3[i] <= DIV_W'(pia_s2[i][0]) + DIV_W'(pia_s2[i][1]) + DIV_W'(pia_s2[i][2]);
				dib_s3[i] <= DIV_W'(pib_s2[i][0]) + DIV_W'(pib_s2[i][1]) + DIV_W'(pib_s2[i][2]);
			end
			iv_s3  <= iv_s2;
			na_s3  <= na_s2;
			nb_s3  <= nb_s2;
			mla_s3 <= mla_s2;
			mlb_s3 <= mlb_s2;
		end
		// stage 4: magnitudes for the face axes
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					anm_s4[i][j] <= dnn_s3[i][j][DNN_W-1] ? DNN_W'(-dnn_s3[i][j])
						: DNN_W'(dnn_s3[i][j]);
				end
				aia_s4[i] <= dia_s3[i][DIV_W-1] ? DIV_W'(-dia_s3[i]) : DIV_W'(dia_s3[i]);
				aib_s4[i] <= dib_s3[i][DIV_W-1] ? DIV_W'(-dib_s3[i]) : DIV_W'(dib_s3[i]);
			end
			mla_s4 <= mla_s3;
			mlb_s4 <= mlb_s3;
		end
		// stage 5: half-width partial products of the face radii
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					for (int m = 0; m < 2; m++) begin
						pfa_s5[i][k][m] <= mlb_s4[k] * anm_pad[i][k][m*FL +: FL];
						pfb_s5[i][k][m] <= mla_s4[k] * anm_pad[k][i][m*FL +: FL];
					end
				end
			end
			aia_s5 <= aia_s4;
			aib_s5 <= aib_s4;
			mla_s5 <= mla_s4;
			mlb_s5 <= mlb_s4;
		end
		if (en[6]) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pja_s6[i][k] <= PF_W'(pfa_s5[i][k][0]) + (PF_W'(pfa_s5[i][k][1]) << FL);
					pjb_s6[i][k] <= PF_W'(pfb_s5[i][k][0]) + (PF_W'(pfb_s5[i][k][1]) << FL);
				end
			end
			aia_s6 <= aia_s5;
			aib_s6 <= aib_s5;
			mla_s6 <= mla_s5;
			mlb_s6 <= mlb_s5;
		end
		// stage 7: own half-length plus the other box's projected extents
		if (en[7]) begin
			for (int i = 0; i < 3; i++) begin
				rfa_s7[i] <= (FR_W'(mla_s6[i]) << (2 * DIR_FRAC)) + FR_W'(pja_s6[i][0])
					+ FR_W'(pja_s6[i][1]) + FR_W'(pja_s6[i][2]);
				rfb_s7[i] <= (FR_W'(mlb_s6[i]) << (2 * DIR_FRAC)) + FR_W'(pjb_s6[i][0])
					+ FR_W'(pjb_s6[i][1]) + FR_W'(pjb_s6[i][2]);
			end
			aia_s7 <= aia_s6;
			aib_s7 <= aib_s6;
		end
		if (en[8]) begin
			for (int i = 0; i < 3; i++) begin
				sepf_s8[i]     <= (CMPF_W'(aia_s7[i]) << DIR_FRAC) > CMPF_W'(rfa_s7[i]);
				sepf_s8[i + 3] <= (CMPF_W'(aib_s7[i]) << DIR_FRAC) > CMPF_W'(rfb_s7[i]);
			end
		end
		if (en[9]) begin
			sepf_s9 <= sepf_s8;
		end
		if (en[10]) begin
			sepf_s10 <= sepf_s9;
		end
		if (en[11]) begin
			sepf_s11 <= sepf_s10;
		end
		if (en[12]) begin
			ovl_s12 <= !(|sepf_s11) && !(|sepx);
		end
	end

	// edge-edge axes: A axis i crossed with B axis j
	for (genvar gi = 0; gi < 3; gi++) begin : g_ai
		for (genvar gj = 0; gj < 3; gj++) begin : g_bj
			obbsat_pkg::comp_t xdir [4][3];
			obbsat_pkg::mag_t  xlen [4];

			always_comb begin
				for (int x = 0; x < 3; x++) begin
					xdir[0][x] = na_s3[(gi + 1) % 3][x];
					xdir[1][x] = na_s3[(gi + 2) % 3][x];
					xdir[2][x] = nb_s3[(gj + 1) % 3][x];
					xdir[3][x] = nb_s3[(gj + 2) % 3][x];
				end
				xlen[0] = mla_s3[(gi + 1) % 3];
				xlen[1] = mla_s3[(gi + 2) % 3];
				xlen[2] = mlb_s3[(gj + 1) % 3];
				xlen[3] = mlb_s3[(gj + 2) % 3];
			end

			obbsat_cross_axis #(
				.DIR_FRAC (DIR_FRAC)
			) u_xaxis (
				.clk     (clk),
				.en      (en),
				.iv      (iv_s3),
				.crs     (crs_s3[gi][gj]),
				.dir     (xdir),
				.len     (xlen),
				.sep_s11 (sepx[3*gi + gj])
			);
		end
	end

endmodule

[rtl/obbsat_checker.sv]
// ---------------------------------------------------------------------------
// obbsat_checker
// Port-level checks on the box overlap pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`include "obb_overlap_separating_axis_assert.svh"

module obbsat_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [obbsat_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// an unblocked output leaves every stage free to move
	`OBBSAT_ASSERT_NOW(a_ready_when_drained, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with output free")

	`OBBSAT_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[obbsat_pkg::OUT_TDATA_W-1:1] == '0, "result pad bits set")

	`OBBSAT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

endmodule

bind obb_overlap_separating_axis obbsat_checker u_obbsat_checker (.*);
